FILE: design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Types, constants and helpers shared by the 4x4 box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int LINE_WIDTH_W = 12;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd1024;
    localparam int SCALE = 4;
    localparam int CHAN_SUM_W = 10;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_TOP     = 2'd0;
    localparam t_phase PH_TOP_AVG = 2'd1;
    localparam t_phase PH_BOT     = 2'd2;
    localparam t_phase PH_OUT     = 2'd3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
    } t_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [CHAN_SUM_W-1:0] red;
        logic [CHAN_SUM_W-1:0] green;
        logic [CHAN_SUM_W-1:0] blue;
    } t_sum;

    typedef struct packed {
        t_pix   pix;
        t_phase phase;
        logic   line_end;
        logic   clear;
    } t_cmd;

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic t_pix avg_pix(input t_pix a, input t_pix b);
        t_pix r;
        r.red   = avg8(a.red, b.red);
        r.green = avg8(a.green, b.green);
        r.blue  = avg8(a.blue, b.blue);
        return r;
    endfunction

endpackage

FILE: design/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front
// Accepts pixels, tracks column and row phase, holds the width register and
// pushes one classified command per pixel into the queue.
// ----------------------------------------------------------------------------
module rbd_front import rbd_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [LINE_WIDTH_W-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    input  t_in                     i_in_data,
    input  logic                    i_q_ready,
    output logic                    o_push,
    output t_cmd                    o_cmd,
    output logic [COL_W-1:0]        o_col
);

    localparam int MW_W = $clog2(MAX_WIDTH + 1);
    localparam int WW   = (LINE_WIDTH_W > MW_W) ? LINE_WIDTH_W : MW_W;
    localparam int CAP  = (MAX_WIDTH / SCALE) * SCALE;
    localparam logic [WW-1:0] W_MIN = WW'(SCALE);
    localparam logic [WW-1:0] W_CAP = WW'(CAP);

    function automatic logic [COL_W-1:0] last_col(input logic [LINE_WIDTH_W-1:0] lw);
        logic [WW-1:0] w;
        w = WW'({lw[LINE_WIDTH_W-1:2], 2'b00});
        if (w < W_MIN) begin
            w = W_MIN;
        end
        if (w > W_CAP) begin
            w = W_CAP;
        end
        return COL_W'(w - WW'(1));
    endfunction

    logic [COL_W-1:0] r_last;
    logic [COL_W-1:0] r_col;
    t_phase           r_phase;
    logic [COL_W-1:0] col;
    t_phase           phase;
    logic             line_end;
    logic             accept;

    assign accept   = i_in_valid && i_q_ready;
    assign col      = i_in_data.frame_start ? '0 : r_col;
    assign phase    = i_in_data.frame_start ? PH_TOP : r_phase;
    assign line_end = (col >= r_last);

    assign o_push         = accept;
    assign o_col          = col;
    assign o_cmd.pix      = '{red: i_in_data.red_in, green: i_in_data.green_in,
                              blue: i_in_data.blue_in};
    assign o_cmd.phase    = phase;
    assign o_cmd.line_end = line_end;
    assign o_cmd.clear    = i_in_data.frame_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= last_col(LINE_WIDTH_RESET);
            r_col   <= '0;
            r_phase <= PH_TOP;
        end else begin
            if (i_cfg_valid) begin
                r_last <= last_col(i_cfg_data);
            end
            if (accept) begin
                if (line_end) begin
                    r_col   <= '0;
                    r_phase <= phase + 2'd1;
                end else begin
                    r_col   <= col + COL_W'(1);
                    r_phase <= phase;
                end
            end
        end
    end

endmodule

FILE: design/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rbd_queue import rbd_pkg::*; #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          do_pop;

    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        unique case ({i_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
        end
    end

endmodule

FILE: design/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back
// Line stores, vertical averaging, horizontal sums and the output register.
// ----------------------------------------------------------------------------
module rbd_back import rbd_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    input  logic [COL_W-1:0] i_q_col,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    t_pix             r_upper [MAX_WIDTH];
    t_pix             r_lower [MAX_WIDTH];
    t_pix             r_up_rd;
    t_pix             r_lo_rd;
    logic             r_b_valid;
    t_cmd             r_b_cmd;
    logic [COL_W-1:0] r_b_col;
    t_sum             r_hsum;
    t_sum             n_hsum;
    t_sum             base;
    t_pix             v;
    logic             r_o_valid;
    t_out             r_o_data;
    logic             out_free;
    logic             advance;
    logic             done;
    logic             emit;
    logic             wr_up;
    logic             wr_lo;
    t_pix             wr_up_data;

    assign out_free = !r_o_valid || i_out_ready;
    assign advance  = !r_b_valid || out_free;
    assign done     = r_b_valid && out_free;
    assign o_pop    = advance && i_q_valid;
    assign emit     = (r_b_cmd.phase == PH_OUT) && (r_b_col[1:0] == 2'b11);

    assign v    = avg_pix(r_up_rd, avg_pix(r_lo_rd, r_b_cmd.pix));
    assign base = r_b_cmd.clear ? '0 : r_hsum;

    always_comb begin
        n_hsum = base;
        if (r_b_cmd.phase == PH_OUT) begin
            n_hsum.red   = base.red + CHAN_SUM_W'(v.red);
            n_hsum.green = base.green + CHAN_SUM_W'(v.green);
            n_hsum.blue  = base.blue + CHAN_SUM_W'(v.blue);
        end
    end

    always_comb begin
        wr_up      = 1'b0;
        wr_lo      = 1'b0;
        wr_up_data = r_b_cmd.pix;
        unique case (r_b_cmd.phase)
            PH_TOP: begin
                wr_up = done;
            end
            PH_TOP_AVG: begin
                wr_up      = done;
                wr_up_data = avg_pix(r_up_rd, r_b_cmd.pix);
            end
            PH_BOT: begin
                wr_lo = done;
            end
            default: begin
            end
        endcase
    end

    // line stores: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (wr_up) begin
            r_upper[r_b_col] <= wr_up_data;
        end
        if (wr_lo) begin
            r_lower[r_b_col] <= r_b_cmd.pix;
        end
        if (o_pop) begin
            r_up_rd <= r_upper[i_q_col];
            r_lo_rd <= r_lower[i_q_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_cmd <= i_q_cmd;
            r_b_col <= i_q_col;
        end
        if (done && emit) begin
            r_o_data.red_out   <= n_hsum.red[CHAN_SUM_W-1:2];
            r_o_data.green_out <= n_hsum.green[CHAN_SUM_W-1:2];
            r_o_data.blue_out  <= n_hsum.blue[CHAN_SUM_W-1:2];
            r_o_data.row_end   <= r_b_cmd.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_hsum    <= '0;
        end else begin
            if (advance) begin
                r_b_valid <= i_q_valid;
            end
            if (out_free) begin
                r_o_valid <= done && emit;
            end
            if (done) begin
                r_hsum <= (emit || r_b_cmd.line_end) ? '0 : n_hsum;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

FILE: design/rgb_box_downscale_4x.sv
// ----------------------------------------------------------------------------
// rgb_box_downscale_4x
// 4x4 box downscaler for a raster RGB pixel stream.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_data  (t_in)
//   out       output     o_out_valid / i_out_ready  o_out_data (t_out)
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (line width)
//
// one pixel per cycle sustained unless the output stalls; results are registered
// the line stores have one write and one read port each, used at most once per pixel
// synchronous active-low reset; the line stores are not cleared
// a stalled output fills the two-entry queue, then input ready drops
// ----------------------------------------------------------------------------
module rgb_box_downscale_4x import rbd_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in                     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out                    o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LINE_WIDTH_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int QW    = $bits(t_cmd) + COL_W;

    logic             push;
    t_cmd             f_cmd;
    logic [COL_W-1:0] f_col;
    logic             q_ready;
    logic             q_valid;
    logic [QW-1:0]    q_data;
    logic             pop;
    t_cmd             b_cmd;
    logic [COL_W-1:0] b_col;

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = q_ready;
    assign {b_cmd, b_col} = q_data;

    rbd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_col       (f_col)
    );

    rbd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_col}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    rbd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (b_cmd),
        .i_q_col     (b_col),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks on the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker import rbd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input t_out                    o_out_data,
    input logic                    o_cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // nothing leaves and input is ready right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("activity right after reset");

    // a result needs an accepted item, so none is seen just after reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |=> !o_out_valid)
        else $error("result without an item");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("width register not writable");

endmodule

bind rgb_box_downscale_4x rbd_checker u_rbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

FILE: bench/tb_rgb_box_downscale_4x.sv
// ----------------------------------------------------------------------------
// tb_rgb_box_downscale_4x
// Self-checking bench for the 4x4 box downscaler. Pixels are streamed in raster
// order under random valid/ready gaps, and each item is run through a software
// copy of the line stores and horizontal sums. Every output item is compared
// field by field. The line width is changed between phases, sometimes in the
// middle of a line, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_rgb_box_downscale_4x;
    timeunit 1ns;
    timeprecision 1ps;
    import rbd_pkg::*;

    localparam int MAX_W = 2048;
    localparam int LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS = 50;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    t_in                     i_in_data = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out                    o_out_data;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [LINE_WIDTH_W-1:0] i_cfg_data = '0;

    // software copy of the block
    t_pix                    upper_store [MAX_W];
    t_pix                    lower_store [MAX_W];
    int                      cur_col;
    t_phase                  cur_phase;
    t_sum                    run_sums;
    logic [LINE_WIDTH_W-1:0] line_width_cfg;

    t_in  pixel_q [$];
    t_out downscaled_q [$];

    int error_count = 0;
    int cycle_count = 0;
    int pixels_accepted = 0;
    int expected_total = 0;
    int results_checked = 0;
    int widths_written = 0;

    int send_gap = 0;
    int send_calm = 0;
    int take_gap = 0;
    int take_calm = 0;
    logic holding = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int taken_n = 0;

    rgb_box_downscale_4x #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int width_in_use(input logic [LINE_WIDTH_W-1:0] value);
        int w;
        w = int'({value[LINE_WIDTH_W-1:2], 2'b00});
        if (w < 4) w = 4;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic logic [7:0] round_mean(input logic [7:0] a, input logic [7:0] b);
        int s;
        s = (int'(a) + int'(b) + 1) >> 1;
        return s[7:0];
    endfunction

    function automatic t_pix mix_pix(input t_pix a, input t_pix b);
        t_pix r;
        r.red   = round_mean(a.red, b.red);
        r.green = round_mean(a.green, b.green);
        r.blue  = round_mean(a.blue, b.blue);
        return r;
    endfunction

    task automatic downscale_pixel(input t_in px);
        t_pix pix;
        t_pix v;
        t_out res;
        int w;
        logic line_end;
        if (px.frame_start) begin
            cur_col = 0;
            cur_phase = PH_TOP;
            run_sums = '0;
        end
        w = width_in_use(line_width_cfg);
        pix.red = px.red_in;
        pix.green = px.green_in;
        pix.blue = px.blue_in;
        line_end = (cur_col >= w - 1);
        case (cur_phase)
            PH_TOP: begin
                upper_store[cur_col] = pix;
            end
            PH_TOP_AVG: begin
                upper_store[cur_col] = mix_pix(upper_store[cur_col], pix);
            end
            PH_BOT: begin
                lower_store[cur_col] = pix;
            end
            default: begin
                v = mix_pix(upper_store[cur_col], mix_pix(lower_store[cur_col], pix));
                run_sums.red = run_sums.red + CHAN_SUM_W'(v.red);
                run_sums.green = run_sums.green + CHAN_SUM_W'(v.green);
                run_sums.blue = run_sums.blue + CHAN_SUM_W'(v.blue);
                if (cur_col % 4 == 3) begin
                    res.red_out = run_sums.red[CHAN_SUM_W-1:2];
                    res.green_out = run_sums.green[CHAN_SUM_W-1:2];
                    res.blue_out = run_sums.blue[CHAN_SUM_W-1:2];
                    res.row_end = line_end;
                    downscaled_q.push_back(res);
                    expected_total++;
                    run_sums = '0;
                end
            end
        endcase
        if (line_end) begin
            cur_col = 0;
            cur_phase = cur_phase + 2'd1;
            run_sums = '0;
        end else begin
            cur_col = cur_col + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch %s: got 0x%0h expected 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (downscaled_q.size() == 0) begin
            report_mismatch("output item with none pending", 32'(got), 32'd0);
            return;
        end
        want = downscaled_q.pop_front();
        results_checked++;
        if (got.red_out !== want.red_out)
            report_mismatch("red_out", 32'(got.red_out), 32'(want.red_out));
        if (got.green_out !== want.green_out)
            report_mismatch("green_out", 32'(got.green_out), 32'(want.green_out));
        if (got.blue_out !== want.blue_out)
            report_mismatch("blue_out", 32'(got.blue_out), 32'(want.blue_out));
        if (got.row_end !== want.row_end)
            report_mismatch("row_end", 32'(got.row_end), 32'(want.row_end));
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
            send_calm <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                downscale_pixel(i_in_data);
                pixels_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pixel_q.size() != 0) begin
                    i_in_data <= pixel_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (send_calm != 0) begin
                        send_calm <= send_calm - 1;
                    end else begin
                        send_gap <= pick_idle();
                        if ($urandom_range(0, 199) == 0) send_calm <= 120;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            take_gap <= 0;
            take_calm <= 0;
        end else begin
            if (o_out_valid && i_out_ready) check_result(o_out_data);
            if (holding) begin
                i_out_ready <= 1'b0;
            end else if (take_gap != 0) begin
                i_out_ready <= 1'b0;
                take_gap <= take_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (take_calm != 0) begin
                    take_calm <= take_calm - 1;
                end else begin
                    if ($urandom_range(0, 3) == 0) take_gap <= pick_idle();
                    if ($urandom_range(0, 199) == 0) take_calm <= 150;
                end
            end
        end
    end

    // one long receiver stall so the command queue fills and input ready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holding <= 1'b0;
            hold_left <= 0;
            taken_n <= 0;
            hold_done <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) taken_n <= taken_n + 1;
            if (holding) begin
                if (hold_left == 1) holding <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && taken_n == 10) begin
                holding <= 1'b1;
                hold_left <= 400;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic settle();
        @(negedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || downscaled_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [LINE_WIDTH_W-1:0] value);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        line_width_cfg = value;
        widths_written++;
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic fs);
        t_in px;
        px.red_in = r;
        px.green_in = g;
        px.blue_in = b;
        px.frame_start = fs;
        pixel_q.push_back(px);
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random(input int n, input logic first_fs, input int noise);
        int k;
        logic fs;
        for (k = 0; k < n; k++) begin
            fs = (k == 0) ? first_fs : (noise != 0 && $urandom_range(0, noise) == 0);
            queue_pixel(rand_byte(), rand_byte(), rand_byte(), fs);
        end
    endtask

    function automatic logic [LINE_WIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return LINE_WIDTH_W'($urandom_range(0, 3));
        if (r < 75) return LINE_WIDTH_W'($urandom_range(4, 24));
        return LINE_WIDTH_W'($urandom_range(25, 48));
    endfunction

    initial begin
        int k;
        int n;
        int row;
        int col;
        int cur_w;
        int new_w;
        int random_px;
        logic fresh;
        logic [LINE_WIDTH_W-1:0] pick;

        for (k = 0; k < MAX_W; k++) begin
            upper_store[k] = '0;
            lower_store[k] = '0;
        end
        cur_col = 0;
        cur_phase = PH_TOP;
        run_sums = '0;
        line_width_cfg = LINE_WIDTH_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: smallest width, saturated block then a rounding pattern
        write_width(12'd4);
        for (k = 0; k < 16; k++)
            queue_pixel(8'd255, 8'd255, 8'd255, k == 0);
        for (k = 0; k < 16; k++) begin
            row = k / 4;
            col = k % 4;
            queue_pixel((row == 0) ? 8'd255 : 8'd0,
                        ((row + col) % 2 == 1) ? 8'd255 : 8'd0,
                        8'(row * 4 + col + 1), k == 0);
        end

        // wider line: one full block row
        write_width(12'd128);
        queue_random(4 * 128, 1'b1, 0);

        // oversized setting, then shrink in the middle of a line
        write_width(12'd4095);
        queue_random(300, 1'b1, 0);
        write_width(12'd8);
        queue_random(16, 1'b0, 0);

        // zero width rounds up to four
        write_width(12'd0);
        queue_random(16, 1'b1, 0);
        cur_w = 4;

        random_px = 0;
        while (random_px < 850 || expected_total < 60) begin
            pick = pick_width();
            new_w = width_in_use(pick);
            // a wider line needs a new frame so no unwritten store entry is read
            fresh = (new_w > cur_w) || ($urandom_range(0, 2) == 0);
            write_width(pick);
            cur_w = new_w;
            n = $urandom_range(0, 6) * new_w + $urandom_range(0, new_w - 1);
            if (n == 0) n = 1;
            queue_random(n, fresh, 250);
            random_px += n;
        end

        settle();
        while (downscaled_q.size() != 0) begin
            report_mismatch("output item never arrived", 32'd0, 32'(downscaled_q.size()));
            void'(downscaled_q.pop_front());
        end
        $display("run covered %0d pixel items over %0d width settings", pixels_accepted,
                 widths_written);
        $display("%0d downscaled items checked, %0d mismatches", results_checked,
                 error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
